// ===== src/sync_bit_packet_deframer_top_assert.svh =====
`ifndef SYNC_BIT_PACKET_DEFRAMER_TOP_ASSERT_SVH
`define SYNC_BIT_PACKET_DEFRAMER_TOP_ASSERT_SVH

// Both macros sample on clk and are switched off while rst_n is low.
`define SBPD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbpd assertion failed");

`define SBPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbpd assertion failed");

`endif

// ===== src/sbpd_pkg.sv =====
package sbpd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned PosW  = 3;
  localparam int unsigned SignW = 7;
  localparam int unsigned DataN = 4;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [PosW-1:0]  pos_t;
  typedef logic [SignW-1:0] sign_t;

  localparam pos_t PosIdle  = 3'd0;
  localparam pos_t PosSign  = 3'd1;
  localparam pos_t PosAddr  = 3'd2;
  localparam pos_t PosData0 = 3'd3;
  localparam pos_t PosData1 = 3'd4;
  localparam pos_t PosData2 = 3'd5;
  localparam pos_t PosData3 = 3'd6;
  localparam pos_t PosCheck = 3'd7;

  localparam int unsigned SignBitCheck  = 0;
  localparam int unsigned SignBitData3  = 1;
  localparam int unsigned SignBitData2  = 2;
  localparam int unsigned SignBitData1  = 3;
  localparam int unsigned SignBitData0  = 4;
  localparam int unsigned SignBitAddr   = 5;
  localparam int unsigned SignBitHeader = 6;

endpackage

// ===== src/sync_bit_packet_deframer_top.sv =====
// Byte-stream deframer for fixed 8-byte packets.
// Input channel: one received byte per transfer on in_rx_byte. A byte with
// bit 7 set starts a packet as its header; it is followed by a sign byte, an
// address, four data bytes and a checksum, all with bit 7 clear. A header
// always restarts the packet, and stray bytes while idle are dropped.
// Output channel: one transfer per packet whose checksum matches, carrying
// the header, address and four data bytes with their top bits restored.
// Throughput is one input byte per cycle while in_ready is high; the result of
// a packet appears on the output register in the cycle after its checksum byte
// is transferred in; the six-operand 8-bit checksum add is combinational.
// When the receiver stalls, the pending result holds and in_ready drops
// until it is taken; a result drained in the same cycle frees the register.
// Reset (rst_n low at a clock edge) returns the receiver to idle and
// empties the output register; held packet bytes are not cleared.
`include "sync_bit_packet_deframer_top_assert.svh"

module sync_bit_packet_deframer_top
  import sbpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_header,
  output logic [7:0] out_address,
  output logic [7:0] out_data_byte0,
  output logic [7:0] out_data_byte1,
  output logic [7:0] out_data_byte2,
  output logic [7:0] out_data_byte3
);

  pos_t  pos_r, pos_nxt;
  byte_t header_r;
  sign_t sign_r;
  byte_t address_r;
  byte_t data_r [DataN];
  logic  out_valid_r, out_valid_nxt;
  byte_t out_header_r, out_address_r;
  byte_t out_data0_r, out_data1_r, out_data2_r, out_data3_r;

  logic  in_fire;
  logic  is_header;
  logic  at_check;
  logic  sum_ok;
  logic  [1:0] data_idx;
  byte_t hdr_fix, adr_fix, d0_fix, d1_fix, d2_fix, d3_fix, chk_fix, sum;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign is_header = in_rx_byte[ByteW-1];
  assign at_check  = (pos_r == PosCheck) && !is_header;
  assign data_idx  = 2'(pos_r[1:0] + 2'd1);

  assign hdr_fix = {sign_r[SignBitHeader], header_r[ByteW-2:0]};
  assign adr_fix = {sign_r[SignBitAddr],   address_r[ByteW-2:0]};
  assign d0_fix  = {sign_r[SignBitData0],  data_r[0][ByteW-2:0]};
  assign d1_fix  = {sign_r[SignBitData1],  data_r[1][ByteW-2:0]};
  assign d2_fix  = {sign_r[SignBitData2],  data_r[2][ByteW-2:0]};
  assign d3_fix  = {sign_r[SignBitData3],  data_r[3][ByteW-2:0]};
  assign chk_fix = {sign_r[SignBitCheck],  in_rx_byte[ByteW-2:0]};
  assign sum     = hdr_fix + adr_fix + d0_fix + d1_fix + d2_fix + d3_fix;
  assign sum_ok  = (sum == chk_fix);

  always_comb begin
    pos_nxt = pos_r;
    if (in_fire) begin
      if (is_header) begin
        pos_nxt = PosSign;
      end else begin
        unique case (pos_r) inside
          PosIdle:  pos_nxt = PosIdle;
          PosSign:  pos_nxt = PosAddr;
          PosAddr:  pos_nxt = PosData0;
          PosData0, PosData1, PosData2, PosData3: pos_nxt = 3'(pos_r + 3'd1);
          PosCheck: pos_nxt = PosIdle;
          default:  pos_nxt = PosIdle;
        endcase
      end
    end
  end

  assign out_valid_nxt = (in_fire && at_check && sum_ok) || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= PosIdle;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (is_header) begin
        header_r <= in_rx_byte;
      end else if (pos_r == PosSign) begin
        sign_r <= in_rx_byte[SignW-1:0];
      end else if (pos_r == PosAddr) begin
        address_r <= in_rx_byte;
      end else if (pos_r >= PosData0 && pos_r <= PosData3) begin
        data_r[data_idx] <= in_rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && at_check && sum_ok) begin
      out_header_r  <= hdr_fix;
      out_address_r <= adr_fix;
      out_data0_r   <= d0_fix;
      out_data1_r   <= d1_fix;
      out_data2_r   <= d2_fix;
      out_data3_r   <= d3_fix;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_header     = out_header_r;
  assign out_address    = out_address_r;
  assign out_data_byte0 = out_data0_r;
  assign out_data_byte1 = out_data1_r;
  assign out_data_byte2 = out_data2_r;
  assign out_data_byte3 = out_data3_r;

  `SBPD_ASSERT_NEXT(a_header_restarts, in_fire && is_header, pos_r == PosSign)
  `SBPD_ASSERT_NEXT(a_check_to_idle, in_fire && at_check, pos_r == PosIdle)
  `SBPD_ASSERT_NEXT(a_good_packet_out, in_fire && at_check && sum_ok, out_valid_r)
  `SBPD_ASSERT_NOW(a_stall_only_full, !in_ready, out_valid_r && !out_ready)

endmodule

// ===== tb/tb_sync_bit_packet_deframer_top.sv =====
`timescale 1ns / 1ps

module tb_sync_bit_packet_deframer_top;
  import sbpd_pkg::*;

  localparam int unsigned QuietLimit = 4000;

  typedef struct packed {
    byte_t                header;
    byte_t                address;
    byte_t [DataN-1:0]    data;
  } frame_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_header;
  logic [7:0] out_address;
  logic [7:0] out_data_byte0;
  logic [7:0] out_data_byte1;
  logic [7:0] out_data_byte2;
  logic [7:0] out_data_byte3;

  int unsigned send_idle_pct = 29;
  int unsigned recv_idle_pct = 46;
  int unsigned quiet_cycles = 0;
  int unsigned error_count = 0;
  int unsigned counted_bytes = 0;
  int unsigned frames_good = 0;
  int unsigned frames_bad = 0;
  int unsigned frames_cut = 0;
  int unsigned frames_seen = 0;

  pos_t   rx_pos = PosIdle;
  byte_t  rx_header;
  sign_t  rx_sign;
  byte_t  rx_address;
  byte_t  rx_data [DataN];
  frame_t expected_frames [$];

  sync_bit_packet_deframer_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_header     (out_header),
    .out_address    (out_address),
    .out_data_byte0 (out_data_byte0),
    .out_data_byte1 (out_data_byte1),
    .out_data_byte2 (out_data_byte2),
    .out_data_byte3 (out_data_byte3)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Restores the top bits and checks the sum once the checksum byte is in.
  task automatic absorb_byte(input byte_t b);
    frame_t f;
    byte_t  chk;
    byte_t  total;
    if (b[7]) begin
      if (rx_pos != PosIdle) begin
        frames_cut++;
      end
      rx_header = b;
      rx_pos = PosSign;
    end else begin
      case (rx_pos)
        PosSign: begin
          rx_sign = b[6:0];
          rx_pos = PosAddr;
        end
        PosAddr: begin
          rx_address = b;
          rx_pos = PosData0;
        end
        PosData0, PosData1, PosData2, PosData3: begin
          rx_data[2'(rx_pos - PosData0)] = b;
          rx_pos = rx_pos + 3'd1;
        end
        PosCheck: begin
          f.header  = {rx_sign[SignBitHeader], rx_header[6:0]};
          f.address = {rx_sign[SignBitAddr], rx_address[6:0]};
          f.data[0] = {rx_sign[SignBitData0], rx_data[0][6:0]};
          f.data[1] = {rx_sign[SignBitData1], rx_data[1][6:0]};
          f.data[2] = {rx_sign[SignBitData2], rx_data[2][6:0]};
          f.data[3] = {rx_sign[SignBitData3], rx_data[3][6:0]};
          chk = {rx_sign[SignBitCheck], b[6:0]};
          total = f.header + f.address + f.data[0] + f.data[1] + f.data[2] + f.data[3];
          if (total == chk) begin
            expected_frames.push_back(f);
            frames_good++;
          end else begin
            frames_bad++;
          end
          rx_pos = PosIdle;
        end
        default: begin
          rx_pos = PosIdle;
        end
      endcase
    end
  endtask

  task automatic send_byte(input byte_t b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (b[7] || rx_pos != PosIdle) begin
      counted_bytes++;
    end
    absorb_byte(b);
  endtask

  task automatic send_packet(input frame_t f, input bit bad_check, input int unsigned cut);
    byte_t       chk;
    sign_t       sign;
    byte_t       frame_bytes [8];
    int unsigned k;
    chk = f.header + f.address + f.data[0] + f.data[1] + f.data[2] + f.data[3];
    sign[SignBitHeader] = f.header[7];
    sign[SignBitAddr]   = f.address[7];
    sign[SignBitData0]  = f.data[0][7];
    sign[SignBitData1]  = f.data[1][7];
    sign[SignBitData2]  = f.data[2][7];
    sign[SignBitData3]  = f.data[3][7];
    sign[SignBitCheck]  = chk[7];
    if (bad_check) begin
      if ($urandom_range(0, 1) == 1) begin
        sign[SignBitCheck] = ~sign[SignBitCheck];
      end else begin
        chk[6:0] = chk[6:0] ^ 7'($urandom_range(1, 127));
      end
    end
    frame_bytes[0] = {1'b1, f.header[6:0]};
    frame_bytes[1] = {1'b0, sign};
    frame_bytes[2] = {1'b0, f.address[6:0]};
    for (k = 0; k < DataN; k++) begin
      frame_bytes[3 + k] = {1'b0, f.data[k][6:0]};
    end
    frame_bytes[7] = {1'b0, chk[6:0]};
    for (k = 0; k < cut; k++) begin
      send_byte(frame_bytes[k]);
    end
  endtask

  function automatic byte_t pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h7F;
      3: return 8'h80;
      default: return byte_t'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic test_stray_bytes();
    send_byte(8'h00);
    send_byte(8'h7F);
  endtask

  task automatic test_extreme_packets();
    frame_t f;
    f = '1;
    send_packet(f, 1'b0, 8);
    f = '0;
    send_packet(f, 1'b0, 8);
  endtask

  task automatic test_abandoned_packet();
    send_byte(8'h80);
    send_byte(8'h7F);
  endtask

  task automatic test_bad_checksum();
    frame_t f;
    f = {8'hA5, 8'h3C, 8'h81, 8'h7E, 8'hC3, 8'h18};
    send_packet(f, 1'b1, 8);
  endtask

  // Mostly well-formed packets, with corrupted, truncated and noisy traffic mixed in.
  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                     input int unsigned n);
    int unsigned stop_at;
    int unsigned roll;
    int unsigned k;
    frame_t      f;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    stop_at = counted_bytes + n;
    while (counted_bytes < stop_at) begin
      f.header = pick_byte();
      f.address = pick_byte();
      for (k = 0; k < DataN; k++) begin
        f.data[k] = pick_byte();
      end
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        send_packet(f, 1'b0, 8);
      end else if (roll < 80) begin
        send_packet(f, 1'b1, 8);
      end else if (roll < 90) begin
        send_packet(f, 1'b0, $urandom_range(1, 7));
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(byte_t'($urandom_range(0, 255)));
      end
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_results
    frame_t want;
    frame_t got;
    int     k;
    if (rst_n && out_valid && out_ready) begin
      got = {out_header, out_address, out_data_byte3, out_data_byte2, out_data_byte1,
             out_data_byte0};
      frames_seen++;
      if (expected_frames.size() == 0) begin
        $error("Unexpected result transfer: out_header %h, out_address %h", out_header,
               out_address);
        error_count++;
      end else begin
        want = expected_frames.pop_front();
        if (got.header !== want.header) begin
          $error("out_header mismatch: expected %h, actual %h", want.header, got.header);
          error_count++;
        end
        if (got.address !== want.address) begin
          $error("out_address mismatch: expected %h, actual %h", want.address, got.address);
          error_count++;
        end
        for (k = 0; k < DataN; k++) begin
          if (got.data[k] !== want.data[k]) begin
            $error("out_data_byte%0d mismatch: expected %h, actual %h", k, want.data[k],
                   got.data[k]);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_stray_bytes();
    test_extreme_packets();
    test_abandoned_packet();
    test_bad_checksum();
    test_random_traffic(29, 46, 390);
    test_random_traffic(46, 29, 380);
    test_random_traffic(0, 0, 380);
    in_valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Run covered %0d packet bytes: %0d good packets, %0d checksum failures,",
             counted_bytes, frames_good, frames_bad);
    $display("%0d packets abandoned by a new header, %0d results transferred.", frames_cut,
             frames_seen);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/sbpd_pkg.sv
src/sync_bit_packet_deframer_top.sv
tb/tb_sync_bit_packet_deframer_top.sv
